// ===== design/gwc_pkg.sv =====
package gwc_pkg;

    localparam int WORD_CHARS_DEF = 64;
    localparam int LINE_SLOTS_DEF = 16;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_SP  = 8'd32;

    localparam logic [5:0] WIDTH_RST = 6'd40;
    localparam logic [4:0] LINES_RST = 5'd10;

    localparam logic CFG_MAX_CHARS = 1'b0;
    localparam logic CFG_MAX_LINES = 1'b1;

    localparam logic KIND_CELL    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        CLS_CR,
        CLS_LF,
        CLS_SEP,
        CLS_WORD
    } cls_t;

    typedef struct packed {
        logic latch_in;
        logic store_char;
        logic plan;
        logic read;
        logic emit_space;
        logic emit_char;
        logic finish_lf;
        logic finish_sep;
        logic finish_end;
        logic emit_sum;
    } cmd_t;

    typedef struct packed {
        logic has;
        logic last;
        logic full;
        cls_t cls;
        logic space;
        logic any;
        logic idx_final;
        logic out_free;
    } sts_t;

endpackage

// ===== design/gwc_ram.sv =====
module gwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gwc_ctrl.sv =====
module gwc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          text_valid,
    output logic          text_stall,
    input  gwc_pkg::sts_t sts,
    output gwc_pkg::cmd_t cmd
);
    import gwc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHAR  = 10'b0000000010,
        S_PLAN  = 10'b0000000100,
        S_ROUTE = 10'b0000001000,
        S_SPACE = 10'b0000010000,
        S_READ  = 10'b0000100000,
        S_EMIT  = 10'b0001000000,
        S_POST  = 10'b0010000000,
        S_LAST  = 10'b0100000000,
        S_SUM   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   end_reg, end_next;

    assign text_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        end_next   = end_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (text_valid)
                begin
                    cmd.latch_in = 1'b1;
                    end_next     = 1'b0;
                    state_next   = S_CHAR;
                end
            end
            S_CHAR:
            begin
                state_next = S_LAST;
                if (sts.has && !sts.full)
                begin
                    unique case (sts.cls) inside
                        CLS_LF, CLS_SEP: state_next = S_PLAN;
                        CLS_WORD:        cmd.store_char = 1'b1;
                        default:         state_next = S_LAST;
                    endcase
                end
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = S_ROUTE;
            end
            S_ROUTE:
            begin
                if (sts.space)
                begin
                    state_next = S_SPACE;
                end
                else if (sts.any)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_SPACE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_space = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    state_next    = sts.idx_final ? S_POST : S_READ;
                end
            end
            S_POST:
            begin
                if (end_reg)
                begin
                    cmd.finish_end = 1'b1;
                    state_next     = S_SUM;
                end
                else
                begin
                    cmd.finish_lf  = (sts.cls == CLS_LF);
                    cmd.finish_sep = (sts.cls != CLS_LF);
                    state_next     = S_LAST;
                end
            end
            S_LAST:
            begin
                if (sts.last)
                begin
                    end_next   = 1'b1;
                    state_next = S_PLAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sum = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg   <= end_next;
        end
    end

endmodule

// ===== design/gwc_dp.sv =====
module gwc_dp #(
    parameter int WORD_CHARS = gwc_pkg::WORD_CHARS_DEF,
    parameter int LINE_SLOTS = gwc_pkg::LINE_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gwc_pkg::cmd_t cmd,
    output gwc_pkg::sts_t sts,
    input  logic [7:0]    char_code,
    input  logic          has_char,
    input  logic          is_last,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [5:0]    cfg_data,
    input  logic          cell_stall,
    output logic          cell_valid,
    output logic          kind,
    output logic [3:0]    line_index,
    output logic [5:0]    column,
    output logic [7:0]    cell_char,
    output logic [4:0]    line_count,
    output logic          last_of_run
);
    import gwc_pkg::*;

    localparam int AW  = $clog2(WORD_CHARS);
    localparam int WLW = $clog2(WORD_CHARS + 1);
    localparam int LDW = $clog2(LINE_SLOTS + 1);
    localparam int PW  = ((WLW > 6) ? WLW : 6) + 1;

    logic [7:0]     char_reg;
    logic           has_reg, last_reg;
    logic [WLW-1:0] wl_reg, wl_next;
    logic [5:0]     ll_reg, ll_next;
    logic [LDW-1:0] ld_reg, ld_next;
    logic           full_reg, full_next;
    logic [5:0]     mcpl_reg;
    logic [4:0]     mln_reg;
    logic [5:0]     col_reg;
    logic [WLW-1:0] cnt_reg, idx_reg;
    logic           space_reg;

    logic           out_valid_reg;
    logic           kind_reg, last_run_reg;
    logic [3:0]     line_reg;
    logic [5:0]     column_reg;
    logic [7:0]     cchar_reg;
    logic [4:0]     lcount_reg;

    logic [5:0]     w;
    logic [LDW-1:0] lim, ld1, ld_push;
    cls_t           cls;
    logic [PW-1:0]  wl_e, w_e, ll_e, fit_e;
    logic [WLW-1:0] wl_p, cnt_p;
    logic [5:0]     ll_p, col_p;
    logic [LDW-1:0] ld_p;
    logic           space_p;
    logic           out_free, idx_final, store_ok;
    logic [7:0]     rdata;
    logic [LDW+3:0] ld_wide;
    logic [LDW-1:0] sum_cnt;
    logic [LDW+4:0] sum_wide;

    assign w   = (mcpl_reg == 6'd0) ? 6'd1 : mcpl_reg;
    assign ld1 = LDW'(ld_reg + 1'b1);

    always_comb
    begin
        if (mln_reg == 5'd0)
        begin
            lim = LDW'(1);
        end
        else if (int'(mln_reg) > LINE_SLOTS)
        begin
            lim = LDW'(LINE_SLOTS);
        end
        else
        begin
            lim = LDW'(mln_reg);
        end
    end

    always_comb
    begin
        unique case (char_reg) inside
            CHAR_CR:           cls = CLS_CR;
            CHAR_LF:           cls = CLS_LF;
            CHAR_SP, CHAR_TAB: cls = CLS_SEP;
            default:           cls = CLS_WORD;
        endcase
    end

    // greedy placement of the buffered word
    assign wl_e  = PW'(wl_reg);
    assign w_e   = PW'(w);
    assign ll_e  = PW'(ll_reg);
    assign fit_e = ll_e + PW'(1) + wl_e;

    always_comb
    begin
        wl_p    = '0;
        ll_p    = ll_reg;
        ld_p    = ld_reg;
        cnt_p   = '0;
        col_p   = 6'd0;
        space_p = 1'b0;
        if (wl_reg != '0 && ld_reg < lim)
        begin
            if (wl_e > w_e)
            begin
                if (ll_reg != 6'd0)
                begin
                    ld_p = ld1;
                    ll_p = 6'd0;
                end
                if (ll_reg == 6'd0 || ld1 < lim)
                begin
                    cnt_p = WLW'(w);
                    ll_p  = w;
                end
            end
            else if (ll_reg == 6'd0)
            begin
                cnt_p = wl_reg;
                ll_p  = 6'(wl_reg);
            end
            else if (fit_e <= w_e)
            begin
                space_p = 1'b1;
                col_p   = ll_reg;
                cnt_p   = wl_reg;
                ll_p    = 6'(fit_e);
            end
            else
            begin
                ld_p = ld1;
                ll_p = 6'd0;
                if (ld1 < lim)
                begin
                    cnt_p = wl_reg;
                    ll_p  = 6'(wl_reg);
                end
            end
        end
    end

    assign ld_push   = (ld_reg < lim) ? ld1 : ld_reg;
    assign store_ok  = (wl_reg != WLW'(WORD_CHARS));
    assign out_free  = !out_valid_reg || !cell_stall;
    assign idx_final = (WLW'(idx_reg + 1'b1) == cnt_reg);

    always_comb
    begin
        wl_next   = wl_reg;
        ll_next   = ll_reg;
        ld_next   = ld_reg;
        full_next = full_reg;
        if (cmd.store_char && store_ok)
        begin
            wl_next = WLW'(wl_reg + 1'b1);
        end
        if (cmd.plan)
        begin
            wl_next = wl_p;
            ll_next = ll_p;
            ld_next = ld_p;
        end
        if (cmd.finish_lf)
        begin
            ld_next = ld_push;
            if (ld_reg < lim)
            begin
                ll_next = 6'd0;
            end
            full_next = (ld_push >= lim);
        end
        if (cmd.finish_sep)
        begin
            full_next = (ld_reg >= lim);
        end
        if (cmd.finish_end && ll_reg != 6'd0 && ld_reg < lim)
        begin
            ld_next = ld1;
            ll_next = 6'd0;
        end
        if (cmd.emit_sum)
        begin
            wl_next   = '0;
            ll_next   = 6'd0;
            ld_next   = '0;
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg        <= '0;
            ll_reg        <= 6'd0;
            ld_reg        <= '0;
            full_reg      <= 1'b0;
            mcpl_reg      <= WIDTH_RST;
            mln_reg       <= LINES_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wl_reg   <= wl_next;
            ll_reg   <= ll_next;
            ld_reg   <= ld_next;
            full_reg <= full_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_CHARS: mcpl_reg <= cfg_data;
                    CFG_MAX_LINES: mln_reg  <= cfg_data[4:0];
                    default:       mcpl_reg <= mcpl_reg;
                endcase
            end
            if (cmd.emit_space || cmd.emit_char || cmd.emit_sum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!cell_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign ld_wide  = {4'd0, ld_reg};
    assign sum_cnt  = (ld_reg == '0) ? LDW'(1) : ld_reg;
    assign sum_wide = {5'd0, sum_cnt};

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            char_reg <= char_code;
            has_reg  <= has_char;
            last_reg <= is_last;
        end
        if (cmd.plan)
        begin
            cnt_reg   <= cnt_p;
            col_reg   <= col_p;
            space_reg <= space_p;
            idx_reg   <= '0;
        end
        if (cmd.emit_space)
        begin
            kind_reg     <= KIND_CELL;
            line_reg     <= ld_wide[3:0];
            column_reg   <= col_reg;
            cchar_reg    <= CHAR_SP;
            lcount_reg   <= 5'd0;
            last_run_reg <= 1'b0;
            col_reg      <= col_reg + 6'd1;
        end
        if (cmd.emit_char)
        begin
            kind_reg     <= KIND_CELL;
            line_reg     <= ld_wide[3:0];
            column_reg   <= col_reg;
            cchar_reg    <= rdata;
            lcount_reg   <= 5'd0;
            last_run_reg <= idx_final && !last_reg;
            col_reg      <= col_reg + 6'd1;
            idx_reg      <= WLW'(idx_reg + 1'b1);
        end
        if (cmd.emit_sum)
        begin
            kind_reg     <= KIND_SUMMARY;
            line_reg     <= 4'd0;
            column_reg   <= 6'd0;
            cchar_reg    <= 8'd0;
            lcount_reg   <= sum_wide[4:0];
            last_run_reg <= 1'b1;
        end
    end

    gwc_ram #(
        .WIDTH(8),
        .DEPTH(WORD_CHARS)
    ) u_word_ram (
        .clk  (clk),
        .we   (cmd.store_char && store_ok),
        .waddr(wl_reg[AW-1:0]),
        .wdata(char_reg),
        .re   (cmd.read),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    assign sts.has       = has_reg;
    assign sts.last      = last_reg;
    assign sts.full      = full_reg;
    assign sts.cls       = cls;
    assign sts.space     = space_reg;
    assign sts.any       = (cnt_reg != '0);
    assign sts.idx_final = idx_final;
    assign sts.out_free  = out_free;

    assign cell_valid  = out_valid_reg;
    assign kind        = kind_reg;
    assign line_index  = line_reg;
    assign column      = column_reg;
    assign cell_char   = cchar_reg;
    assign line_count  = lcount_reg;
    assign last_of_run = last_run_reg;

endmodule

// ===== design/greedy_word_wrap_cells_core.sv =====
// channel | direction | handshake                | payload
// text    | in        | text_valid / text_stall  | char_code, has_char, is_last
// cell    | out       | cell_valid / cell_stall  | kind, line_index, column, cell_char,
//         |           |                          | line_count, last_of_run
// cfg     | in        | cfg_we                   | cfg_index, cfg_data
//
// One word at a time. A space, tab or LF places the buffered word cell by cell,
// reading each character through the single read port of the word buffer;
// end of text places any word still buffered and then sends the summary.
// Reset clears all control state; the word buffer needs no clearing.
// A stall on cell holds the current word and pauses placement.
module greedy_word_wrap_cells_core #(
    parameter int WORD_CHARS = gwc_pkg::WORD_CHARS_DEF,
    parameter int LINE_SLOTS = gwc_pkg::LINE_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] char_code,
    input  logic       has_char,
    input  logic       is_last,
    output logic       cell_valid,
    input  logic       cell_stall,
    output logic       kind,
    output logic [3:0] line_index,
    output logic [5:0] column,
    output logic [7:0] cell_char,
    output logic [4:0] line_count,
    output logic       last_of_run,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data
);
    import gwc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gwc_dp #(
        .WORD_CHARS(WORD_CHARS),
        .LINE_SLOTS(LINE_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .char_code  (char_code),
        .has_char   (has_char),
        .is_last    (is_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_stall (cell_stall),
        .cell_valid (cell_valid),
        .kind       (kind),
        .line_index (line_index),
        .column     (column),
        .cell_char  (cell_char),
        .line_count (line_count),
        .last_of_run(last_of_run)
    );

endmodule

// ===== design/gwc_checker.sv =====
module gwc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_stall,
    input logic       cell_valid,
    input logic       cell_stall,
    input logic       kind,
    input logic [3:0] line_index,
    input logic [5:0] column,
    input logic [7:0] cell_char,
    input logic [4:0] line_count,
    input logic       last_of_run
);
    import gwc_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_stall |=> cell_valid && $stable(column) && $stable(cell_char)
            && $stable(kind) && $stable(line_count))
        else $error("stalled cell word changed");

    // one text word in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall |=> text_stall)
        else $error("text taken while busy");

    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && kind == KIND_SUMMARY |-> last_of_run && line_count != 5'd0)
        else $error("bad summary word");

    a_cell_shape: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && kind == KIND_CELL |-> line_count == 5'd0 && column != 6'd63)
        else $error("bad cell word");

endmodule

bind greedy_word_wrap_cells_core gwc_checker u_gwc_checker (.*);
